// ===== rtl/price_time_order_book_macros.svh =====
// Assertion macros for the order book RTL
`ifndef PRICE_TIME_ORDER_BOOK_MACROS_SVH
`define PRICE_TIME_ORDER_BOOK_MACROS_SVH
// Implication checked on every rising clock edge outside reset
`define PTOB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset
`define PTOB_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== rtl/ptob_pkg.sv =====
// ----------------------------------------------------------------------------
// ptob_pkg
// Types, constants and codes shared by the order book modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ptob_pkg;
  localparam int SIDE_DEPTH = 64;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0, OP_CANCEL = 2'd1, OP_FIND = 2'd2, OP_UPDATE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NOT_FOUND = 2'd1, ST_DUPLICATE = 2'd2, ST_FULL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE, S_ACT, S_OUT
  } state_t;

  typedef struct packed {
    logic [30:0] id;
    logic [31:0] price;
    logic [47:0] tstamp;
    logic [31:0] qty;
  } entry_t;

  // command broadcast to every cell of one side
  typedef struct packed {
    logic        ins;     // insert new entry
    logic        rem;     // remove hit entry
    logic        upd;     // overwrite quantity of hit entry
    logic        is_sell;
    entry_t      ent;
  } cmd_t;

  // summary returned by a side
  typedef struct packed {
    logic   hit;
    entry_t hit_ent;
    logic   head_valid;
    entry_t head;
    logic   full;
  } side_stat_t;
endpackage

// ===== rtl/ptob_if.sv =====
// ----------------------------------------------------------------------------
// ptob_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface ptob_in_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [30:0] order_id;
  logic        side;
  logic [31:0] limit_price;
  logic [47:0] arrival_time;
  logic signed [31:0] open_quantity;
  modport source (output valid, operation, order_id, side, limit_price,
                  arrival_time, open_quantity, input ready);
  modport sink (input valid, operation, order_id, side, limit_price,
                arrival_time, open_quantity, output ready);
endinterface

interface ptob_out_if (input logic clk);
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        found_side;
  logic [31:0] found_price;
  logic [47:0] found_time;
  logic signed [31:0] found_quantity;
  logic        bid_valid;
  logic [30:0] best_bid_id;
  logic [31:0] best_bid_price;
  logic        ask_valid;
  logic [30:0] best_ask_id;
  logic [31:0] best_ask_price;
  modport source (output valid, status, found_side, found_price, found_time,
                  found_quantity, bid_valid, best_bid_id, best_bid_price,
                  ask_valid, best_ask_id, best_ask_price, input ready);
  modport sink (input valid, status, found_side, found_price, found_time,
                found_quantity, bid_valid, best_bid_id, best_bid_price,
                ask_valid, best_ask_id, best_ask_price, output ready);
endinterface

// ===== rtl/ptob_cell.sv =====
// ----------------------------------------------------------------------------
// ptob_cell
// One slot of a sorted side: holds an entry, compares and shifts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ptob_cell (
  input  logic            clk,
  input  logic            rst,
  input  ptob_pkg::cmd_t  cmd,
  input  logic            prev_valid,   // neighbour towards the head
  input  ptob_pkg::entry_t prev_ent,
  input  logic            prev_ahead,   // new entry ranks ahead of prev
  input  logic            prev_past,    // hit lies at or above prev
  input  logic            next_valid,   // neighbour towards the tail
  input  ptob_pkg::entry_t next_ent,
  output logic            valid,
  output ptob_pkg::entry_t ent,
  output logic            ahead,
  output logic            past,
  output logic            hit
);
  import ptob_pkg::*;

  logic   valid_next;
  entry_t ent_next;
  logic   lo_rank;

  // rank compare: new ahead of held when better price, or same price and older
  always_comb begin
    if (cmd.ent.price != ent.price)
      lo_rank = cmd.is_sell ? (cmd.ent.price < ent.price)
                            : (cmd.ent.price > ent.price);
    else
      lo_rank = cmd.ent.tstamp < ent.tstamp;
  end

  assign hit   = valid && (ent.id == cmd.ent.id);
  // ahead: insertion point is at or before this cell
  assign ahead = prev_ahead || !valid || lo_rank;
  assign past  = prev_past || hit;

  // shift for insert / remove, overwrite for update
  always_comb begin
    valid_next = valid;
    ent_next   = ent;
    if (cmd.ins) begin
      if (prev_ahead) begin
        valid_next = prev_valid;
        ent_next   = prev_ent;
      end else if (ahead) begin
        valid_next = 1'b1;
        ent_next   = cmd.ent;
      end
    end else if (cmd.rem) begin
      if (past) begin
        valid_next = next_valid;
        ent_next   = next_ent;
      end
    end else if (cmd.upd && hit) begin
      ent_next.qty = cmd.ent.qty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) valid <= 1'b0;
    else     valid <= valid_next;
    ent <= ent_next;
  end
endmodule

// ===== rtl/ptob_side.sv =====
// ----------------------------------------------------------------------------
// ptob_side
// Chain of cells holding one side of the book, head at cell zero.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ptob_side (
  input  logic               clk,
  input  logic               rst,
  input  ptob_pkg::cmd_t     cmd,
  output ptob_pkg::side_stat_t stat
);
  import ptob_pkg::*;

  logic   [SIDE_DEPTH-1:0] v, ah, ps, ht;
  entry_t                  e [SIDE_DEPTH];
  entry_t                  hit_ent;

  for (genvar i = 0; i < SIDE_DEPTH; i++) begin : g_cell
    ptob_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .cmd       (cmd),
      .prev_valid(i == 0 ? 1'b0 : v[(i == 0) ? 0 : i-1]),
      .prev_ent  (e[(i == 0) ? 0 : i-1]),
      .prev_ahead(i == 0 ? 1'b0 : ah[(i == 0) ? 0 : i-1]),
      .prev_past (i == 0 ? 1'b0 : ps[(i == 0) ? 0 : i-1]),
      .next_valid(i == SIDE_DEPTH-1 ? 1'b0 : v[(i == SIDE_DEPTH-1) ? i : i+1]),
      .next_ent  (e[(i == SIDE_DEPTH-1) ? i : i+1]),
      .valid     (v[i]),
      .ent       (e[i]),
      .ahead     (ah[i]),
      .past      (ps[i]),
      .hit       (ht[i])
    );
  end

  // ids are unique, so an OR of masked entries picks the hit
  always_comb begin
    hit_ent = '0;
    for (int i = 0; i < SIDE_DEPTH; i++)
      if (ht[i]) hit_ent = hit_ent | e[i];
  end

  assign stat.hit        = |ht;
  assign stat.hit_ent    = hit_ent;
  assign stat.head_valid = v[0];
  assign stat.head       = e[0];
  assign stat.full       = v[SIDE_DEPTH-1];
endmodule

// ===== rtl/price_time_order_book.sv =====
// ----------------------------------------------------------------------------
// price_time_order_book
// Two price-time priority order lists built as chains of sorted cells.
// ----------------------------------------------------------------------------
// Channel  Dir  Transaction
// in       in   one operation: add, cancel, find or update
// out      out  status, order concerned and best bid / best ask
//
// Each item passes through accept, a work step in which every cell
// compares against the broadcast order and shifts or updates, then a result
// register that waits for the sink. Reset clears the cell valid bits.
// A stalled result holds the block; no new item is taken meanwhile.
`timescale 1ns / 1ps
`include "price_time_order_book_macros.svh"
module price_time_order_book (
  input logic clk,
  input logic rst,
  ptob_in_if.sink    in,
  ptob_out_if.source out
);
  import ptob_pkg::*;

  state_t     state, state_next;
  cmd_t       bid_cmd, ask_cmd;
  side_stat_t bid_stat, ask_stat;
  logic [1:0] op;
  entry_t     req;
  logic       req_side;
  logic       in_sell;
  entry_t     fnd;
  logic       remove;
  status_t    st;

  ptob_side u_bid (.clk(clk), .rst(rst), .cmd(bid_cmd), .stat(bid_stat));
  ptob_side u_ask (.clk(clk), .rst(rst), .cmd(ask_cmd), .stat(ask_stat));

  // capture request
  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      op       <= in.operation;
      req_side <= in.side;
      req      <= '{in.order_id, in.limit_price, in.arrival_time,
                    in.open_quantity};
    end
  end

  // decide the operation from the side summaries
  always_comb begin
    in_sell = !bid_stat.hit && ask_stat.hit;
    fnd     = in_sell ? ask_stat.hit_ent : bid_stat.hit_ent;
    st      = ST_OK;
    remove  = 1'b0;
    if (op == OP_ADD) begin
      if (bid_stat.hit || ask_stat.hit) st = ST_DUPLICATE;
      else if (req_side ? ask_stat.full : bid_stat.full) st = ST_FULL;
    end else if (!(bid_stat.hit || ask_stat.hit)) begin
      st = ST_NOT_FOUND;
    end else begin
      if (op == OP_UPDATE) fnd.qty = req.qty;
      remove = (op == OP_CANCEL) ||
               (op == OP_UPDATE && (req.qty == '0 || req.qty[31]));
    end
  end

  // commands to the chains, active only in the work cycle
  always_comb begin
    logic act;
    act = (state == S_ACT);
    bid_cmd = '0;
    ask_cmd = '0;
    bid_cmd.ent = req;
    ask_cmd.ent = req;
    ask_cmd.is_sell = 1'b1;
    bid_cmd.ins = act && op == OP_ADD && st == ST_OK && !req_side;
    ask_cmd.ins = act && op == OP_ADD && st == ST_OK && req_side;
    bid_cmd.rem = act && remove && !in_sell;
    ask_cmd.rem = act && remove && in_sell;
    bid_cmd.upd = act && op == OP_UPDATE && st == ST_OK && !in_sell;
    ask_cmd.upd = act && op == OP_UPDATE && st == ST_OK && in_sell;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in.valid) state_next = S_ACT;
      S_ACT:   state_next = S_OUT;
      S_OUT:   if (out.ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // result register: found fields in work cycle, heads after the update
  always_ff @(posedge clk) begin
    if (state == S_ACT) begin
      out.status         <= st;
      out.found_side     <= (st == ST_OK && op != OP_ADD) ? in_sell : 1'b0;
      out.found_price    <= (st == ST_OK && op != OP_ADD) ? fnd.price : '0;
      out.found_time     <= (st == ST_OK && op != OP_ADD) ? fnd.tstamp : '0;
      out.found_quantity <= (st == ST_OK && op != OP_ADD) ? fnd.qty : '0;
    end
  end

  // outputs
  assign in.ready           = (state == S_IDLE);
  assign out.valid          = (state == S_OUT);
  assign out.bid_valid      = bid_stat.head_valid;
  assign out.best_bid_id    = bid_stat.head_valid ? bid_stat.head.id : '0;
  assign out.best_bid_price = bid_stat.head_valid ? bid_stat.head.price : '0;
  assign out.ask_valid      = ask_stat.head_valid;
  assign out.best_ask_id    = ask_stat.head_valid ? ask_stat.head.id : '0;
  assign out.best_ask_price = ask_stat.head_valid ? ask_stat.head.price : '0;

  `PTOB_ASSERT_IMP(a_excl, 1'b1, !(in.ready && out.valid))
  `PTOB_ASSERT_NEXT(a_act_out, state == S_ACT, out.valid)
  `PTOB_ASSERT_IMP(a_one_hit, state == S_ACT, !(bid_stat.hit && ask_stat.hit))
endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// Order book regression bench
// Drives add, cancel, find and update operations through the input channel and
// checks every result against an in-bench model of both sorted order lists.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module testbench;
  import ptob_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int N_RANDOM = 250;
  localparam int ID_POOL = 96;

  typedef struct packed {
    logic [1:0]         status;
    logic               found_side;
    logic [31:0]        found_price;
    logic [47:0]        found_time;
    logic signed [31:0] found_quantity;
    logic               bid_valid;
    logic [30:0]        best_bid_id;
    logic [31:0]        best_bid_price;
    logic               ask_valid;
    logic [30:0]        best_ask_id;
    logic [31:0]        best_ask_price;
  } book_result_t;

  typedef struct {
    op_t                op;
    logic [30:0]        id;
    logic               sd;
    logic [31:0]        price;
    logic [47:0]        tstamp;
    logic signed [31:0] qty;
    bit                 has_status;
    status_t            want_status;
  } stim_row_t;

  logic clk = 0;
  logic rst = 1;
  ptob_in_if  cmd_ch (clk);
  ptob_out_if res_ch (clk);

  price_time_order_book DUT (.clk(clk), .rst(rst), .in(cmd_ch.sink), .out(res_ch.source));

  // model of the two lists; index 0 is the head
  entry_t book [2][$];
  book_result_t pending_results [$];
  int mismatches = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int ops_sent [4] = '{0, 0, 0, 0};
  int status_seen [4] = '{0, 0, 0, 0};

  initial begin
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_results.size());
      $display("price_time_order_book regression: fail");
      $finish;
    end
  end

  // place of a new order: behind every held order ranking equal or ahead
  function automatic int insert_place(int s, logic [31:0] p, logic [47:0] t);
    int pos;
    pos = 0;
    while (pos < book[s].size()) begin
      if (p != book[s][pos].price) begin
        if (s == 1 ? (p < book[s][pos].price) : (p > book[s][pos].price)) break;
      end else if (t < book[s][pos].tstamp) begin
        break;
      end
      pos++;
    end
    return pos;
  endfunction

  function automatic book_result_t apply_book_op(stim_row_t r);
    book_result_t res;
    int hs, hp, pos;
    res = '{default: '0};
    hs = -1;
    hp = 0;
    for (int s = 0; s < 2 && hs < 0; s++)
      for (int i = 0; i < book[s].size(); i++)
        if (book[s][i].id == r.id) begin
          hs = s;
          hp = i;
          break;
        end
    if (r.op == OP_ADD) begin
      if (hs >= 0) res.status = ST_DUPLICATE;
      else if (book[r.sd].size() >= SIDE_DEPTH) res.status = ST_FULL;
      else begin
        pos = insert_place(r.sd, r.price, r.tstamp);
        book[r.sd].insert(pos, entry_t'{id: r.id, price: r.price, tstamp: r.tstamp,
                                        qty: r.qty});
      end
    end else if (hs < 0) begin
      res.status = ST_NOT_FOUND;
    end else begin
      if (r.op == OP_UPDATE) book[hs][hp].qty = r.qty;
      res.found_side = hs[0];
      res.found_price = book[hs][hp].price;
      res.found_time = book[hs][hp].tstamp;
      res.found_quantity = book[hs][hp].qty;
      if (r.op == OP_CANCEL || (r.op == OP_UPDATE && r.qty <= 0)) book[hs].delete(hp);
    end
    if (book[0].size() > 0) begin
      res.bid_valid = 1;
      res.best_bid_id = book[0][0].id;
      res.best_bid_price = book[0][0].price;
    end
    if (book[1].size() > 0) begin
      res.ask_valid = 1;
      res.best_ask_id = book[1][0].id;
      res.best_ask_price = book[1][0].price;
    end
    return res;
  endfunction

  // send one transaction after a random gap, record its expectation
  task automatic send_order(stim_row_t r);
    book_result_t exp_res;
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
    // valid stays up only when the next transaction follows straight away
    if (gap > 0) begin
      cmd_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1;
    cmd_ch.operation <= r.op;
    cmd_ch.order_id <= r.id;
    cmd_ch.side <= r.sd;
    cmd_ch.limit_price <= r.price;
    cmd_ch.arrival_time <= r.tstamp;
    cmd_ch.open_quantity <= r.qty;
    do @(posedge clk); while (!cmd_ch.ready);
    exp_res = apply_book_op(r);
    if (r.has_status && exp_res.status != r.want_status) begin
      $display("table row disagrees: op %0d id %0d status %0d, table %0d",
               r.op, r.id, exp_res.status, r.want_status);
    end
    if (r.has_status) exp_res.status = r.want_status;
    pending_results = {pending_results, exp_res};
    ops_sent[r.op]++;
  endtask

  // result side: random stall per transaction, then compare against the oldest
  initial begin
    book_result_t e;
    book_result_t a;
    int stall;
    res_ch.ready = 0;
    @(negedge rst);
    stall = $urandom_range(0, 13);
    forever begin
      @(posedge clk);
      if (res_ch.valid && res_ch.ready) begin
        a = '{res_ch.status, res_ch.found_side, res_ch.found_price, res_ch.found_time,
              res_ch.found_quantity, res_ch.bid_valid, res_ch.best_bid_id,
              res_ch.best_bid_price, res_ch.ask_valid, res_ch.best_ask_id,
              res_ch.best_ask_price};
        results_seen++;
        stall = $urandom_range(0, 13);
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: %p", a);
        end else begin
          e = pending_results.pop_front();
          status_seen[e.status]++;
          if (a !== e) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch\n  expected %p\n  actual   %p", e, a);
          end
        end
      end
      // hold ready low until the drawn stall count runs out, counting down only with a result waiting
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        if (res_ch.valid) stall--;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  function automatic stim_row_t mk(op_t op, int id, bit sd, logic [31:0] p, logic [47:0] t,
                                   int q, bit hs = 0, status_t st = ST_OK);
    stim_row_t r;
    r = '{op, id[30:0], sd, p, t, q, hs, st};
    return r;
  endfunction

  function automatic stim_row_t random_row();
    stim_row_t r;
    int k;
    k = $urandom_range(0, 99);
    r.op = k < 45 ? OP_ADD : k < 62 ? OP_CANCEL : k < 78 ? OP_FIND : OP_UPDATE;
    r.id = ($urandom_range(0, 19) == 0) ? 31'($urandom) : 31'($urandom_range(1, ID_POOL));
    r.sd = 1'($urandom_range(0, 1));
    // narrow prices and times give many ties; occasional full-width values
    r.price = ($urandom_range(0, 7) == 0) ? $urandom : 1000 + $urandom_range(0, 12);
    r.tstamp = ($urandom_range(0, 7) == 0) ? 48'({$urandom, $urandom})
                                           : 48'($urandom_range(0, 5));
    r.qty = ($urandom_range(0, 4) == 0) ? $signed($urandom) : $urandom_range(0, 50) - 5;
    r.has_status = 0;
    r.want_status = ST_OK;
    return r;
  endfunction

  initial begin
    stim_row_t directed [$];
    cmd_ch.valid = 0;
    cmd_ch.operation = OP_ADD;
    cmd_ch.order_id = 0;
    cmd_ch.side = 0;
    cmd_ch.limit_price = 0;
    cmd_ch.arrival_time = 0;
    cmd_ch.open_quantity = 0;
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed table: empty book, extremes, ties, errors, removal by update
    directed = '{
      mk(OP_FIND, 5, 0, 0, 0, 0, 1, ST_NOT_FOUND),
      mk(OP_CANCEL, 31'h7FFFFFFF, 0, 0, 0, 0, 1, ST_NOT_FOUND),
      mk(OP_UPDATE, 0, 0, 0, 0, 3, 1, ST_NOT_FOUND),
      mk(OP_ADD, 0, 0, 32'h0, 48'h0, 32'sh80000000, 1, ST_OK),
      mk(OP_ADD, 31'h7FFFFFFF, 1, 32'hFFFFFFFF, 48'hFFFFFFFFFFFF, 32'sh7FFFFFFF, 1, ST_OK),
      mk(OP_ADD, 1, 0, 100, 7, 10),
      mk(OP_ADD, 2, 0, 100, 7, 11),
      mk(OP_ADD, 3, 0, 100, 3, 12),
      mk(OP_ADD, 4, 1, 50, 9, 0),
      mk(OP_ADD, 5, 1, 50, 9, 1),
      mk(OP_ADD, 2, 1, 1, 1, 1, 1, ST_DUPLICATE),
      mk(OP_ADD, 31'h7FFFFFFF, 0, 5, 5, 5, 1, ST_DUPLICATE),
      mk(OP_FIND, 2, 0, 0, 0, 0),
      mk(OP_UPDATE, 5, 0, 0, 0, 99),
      mk(OP_UPDATE, 4, 0, 0, 0, 0),
      mk(OP_UPDATE, 1, 0, 0, 0, -1),
      mk(OP_CANCEL, 3, 0, 0, 0, 0),
      mk(OP_CANCEL, 3, 0, 0, 0, 0, 1, ST_NOT_FOUND),
      mk(OP_FIND, 31'h7FFFFFFF, 0, 0, 0, 0),
      mk(OP_CANCEL, 0, 0, 0, 0, 0)
    };
    foreach (directed[i]) send_order(directed[i]);

    // fill the buy side to capacity, then one add too many
    for (int i = 0; i < SIDE_DEPTH - book[0].size(); i = 0)
      send_order(mk(OP_ADD, 5000 + book[0].size(), 0, $urandom_range(0, 3), 0, 1));
    send_order(mk(OP_ADD, 6000, 0, 1, 1, 1, 1, ST_FULL));
    // hold off until the book has answered everything
    cmd_ch.valid <= 0;
    wait (pending_results.size() == 0);
    while (book[0].size() > 0) send_order(mk(OP_CANCEL, book[0][0].id, 0, 0, 0, 0));
    while (book[1].size() > 0) send_order(mk(OP_CANCEL, book[1][0].id, 0, 0, 0, 0));

    for (int n = 0; n < N_RANDOM; n++) send_order(random_row());
    cmd_ch.valid <= 0;

    wait (pending_results.size() == 0);
    repeat (20) @(posedge clk);
    $display("ran %0d add, %0d cancel, %0d find, %0d update; %0d results checked",
             ops_sent[0], ops_sent[1], ops_sent[2], ops_sent[3], results_seen);
    $display("status counts ok %0d, not found %0d, duplicate %0d, full %0d; %0d mismatches",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3], mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("price_time_order_book regression: pass");
    end else begin
      $display("price_time_order_book regression: fail");
    end
    $finish;
  end
endmodule
